@@ rtl/nprt_pkg.sv @@
// ----------------------------------------------------------------------------
// nprt_pkg
// Shared types, constants and fixed-point helpers for the Newton root finder.
// ----------------------------------------------------------------------------
package nprt_pkg;

  localparam int DATA_W        = 64;
  localparam int FRACTION_BITS = 32;
  localparam int MAX_TERMS     = 5;
  localparam int MAX_ITER      = 64;
  localparam int IT_W          = $clog2(MAX_ITER + 1);

  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [2:0] REG_TERMS = 3'd5;
  localparam logic [2:0] REG_TOL   = 3'd6;
  localparam logic [2:0] REG_MINS  = 3'd7;

  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_SMALL = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LDX,
    OP_ZERO,
    OP_LOAD_C,
    OP_LOAD_S,
    OP_MUL,
    OP_ADD_C,
    OP_ADD_S,
    OP_SAVE_FP,
    OP_DIV,
    OP_STEP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       fp_zero;
    logic       fp_small;
    logic       delta_small;
    logic [2:0] terms;
  } dp_status_t;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] sat128(input logic neg,
                                               input logic [2*DATA_W-1:0] m);
    if (neg) begin
      if (m > {{DATA_W{1'b0}}, NEG_MIN}) return NEG_MIN;
      return ~m[DATA_W-1:0] + 1'b1;
    end
    if (m > {{DATA_W{1'b0}}, POS_MAX}) return POS_MAX;
    return m[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] add_sat(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    s = a + b;
    if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1])
      return a[DATA_W-1] ? NEG_MIN : POS_MAX;
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] sub_sat(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    s = a - b;
    if (a[DATA_W-1] != b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1])
      return a[DATA_W-1] ? NEG_MIN : POS_MAX;
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] int_scale(input logic [DATA_W-1:0] a,
                                                  input logic [2:0] k);
    logic [DATA_W+2:0] p;
    p = mag(a) * k;
    return sat128(a[DATA_W-1], {{(DATA_W-3){1'b0}}, p});
  endfunction

endpackage

@@ rtl/nprt_dp.sv @@
// ----------------------------------------------------------------------------
// nprt_dp
// Datapath: configuration registers, Horner accumulator, sequenced 32x32
// multiplier and bit-serial restoring divider.
// ----------------------------------------------------------------------------
module nprt_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [nprt_pkg::DATA_W-1:0] cfg_data,
  input  logic [nprt_pkg::DATA_W-1:0] start_point,
  input  nprt_pkg::dp_cmd_t         cmd,
  output nprt_pkg::dp_status_t      status,
  output logic [nprt_pkg::DATA_W-1:0] x_out
);
  import nprt_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mode_t;

  logic [DATA_W-1:0]   coeff_r [MAX_TERMS];
  logic [2:0]          tc_r;
  logic [DATA_W-2:0]   tol_r, mins_r;
  logic [DATA_W-1:0]   x_r, acc_r, fp_r, dl_r, ma_r, mb_r, rem_r, pp_r;
  logic [DATA_W-1:0]   x_nxt, acc_nxt, fp_nxt, dl_nxt, ma_nxt, mb_nxt, rem_nxt, pp_nxt;
  logic [2*DATA_W-1:0] sum_r, sum_nxt, num_r, num_nxt;
  logic [1:0]          ps_r, ps_nxt;
  logic                neg_r, neg_nxt;
  logic [7:0]          cnt_r, cnt_nxt;
  mode_t               mode_r, mode_nxt;

  logic [DATA_W-1:0]   cval;
  logic [31:0]         pa, pb;
  logic [2*DATA_W-1:0] pp_sh;
  logic [DATA_W:0]     r2;
  logic                ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TERMS; i++) coeff_r[i] <= '0;
      tc_r   <= '0;
      tol_r  <= (DATA_W-1)'(4);
      mins_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TERMS: tc_r   <= cfg_data[2:0];
        REG_TOL:   tol_r  <= cfg_data[DATA_W-2:0];
        REG_MINS:  mins_r <= cfg_data[DATA_W-2:0];
        default:   coeff_r[cfg_index] <= cfg_data;
      endcase
    end
  end

  assign cval = (cmd.idx < 3'(MAX_TERMS)) ? coeff_r[cmd.idx] : '0;
  assign pa   = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign pb   = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pp_sh = (ps_r == 2'd0) ? {{DATA_W{1'b0}}, pp_r} :
                 (ps_r == 2'd3) ? {pp_r, {DATA_W{1'b0}}} :
                                  {32'b0, pp_r, 32'b0};
  assign r2 = {rem_r, num_r[2*DATA_W-1]};
  assign ge = r2 >= {1'b0, ma_r};

  always_comb begin
    x_nxt = x_r; acc_nxt = acc_r; fp_nxt = fp_r; dl_nxt = dl_r;
    ma_nxt = ma_r; mb_nxt = mb_r; rem_nxt = rem_r; pp_nxt = pp_r;
    sum_nxt = sum_r; num_nxt = num_r; ps_nxt = ps_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; mode_nxt = mode_r;
    case (mode_r)
      M_MUL: begin
        if (cnt_r < 8'd4) begin
          pp_nxt = pa * pb;
          ps_nxt = cnt_r[1:0];
        end
        if (cnt_r >= 8'd1 && cnt_r <= 8'd4) sum_nxt = sum_r + pp_sh;
        if (cnt_r == 8'd5) begin
          acc_nxt  = sat128(neg_r, sum_r >> FRACTION_BITS);
          mode_nxt = M_IDLE;
        end
        cnt_nxt = cnt_r + 8'd1;
      end
      M_DIV: begin
        if (cnt_r[7]) begin
          dl_nxt   = sat128(neg_r, num_r);
          mode_nxt = M_IDLE;
        end else begin
          rem_nxt = ge ? DATA_W'(r2 - {1'b0, ma_r}) : r2[DATA_W-1:0];
          num_nxt = {num_r[2*DATA_W-2:0], ge};
        end
        cnt_nxt = cnt_r + 8'd1;
      end
      default: begin
        case (cmd.op)
          OP_LDX:     x_nxt = start_point;
          OP_ZERO:    acc_nxt = '0;
          OP_LOAD_C:  acc_nxt = cval;
          OP_LOAD_S:  acc_nxt = int_scale(cval, cmd.idx);
          OP_ADD_C:   acc_nxt = add_sat(acc_r, cval);
          OP_ADD_S:   acc_nxt = add_sat(acc_r, int_scale(cval, cmd.idx));
          OP_SAVE_FP: fp_nxt = acc_r;
          OP_STEP:    x_nxt = sub_sat(x_r, dl_r);
          OP_MUL: begin
            ma_nxt = mag(acc_r); mb_nxt = mag(x_r);
            neg_nxt = acc_r[DATA_W-1] ^ x_r[DATA_W-1];
            sum_nxt = '0; cnt_nxt = '0; mode_nxt = M_MUL;
          end
          OP_DIV: begin
            ma_nxt = mag(fp_r);
            num_nxt = {{DATA_W{1'b0}}, mag(acc_r)} << FRACTION_BITS;
            neg_nxt = acc_r[DATA_W-1] ^ fp_r[DATA_W-1];
            rem_nxt = '0; cnt_nxt = '0; mode_nxt = M_DIV;
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= M_IDLE;
    else        mode_r <= mode_nxt;
    x_r <= x_nxt; acc_r <= acc_nxt; fp_r <= fp_nxt; dl_r <= dl_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; rem_r <= rem_nxt; pp_r <= pp_nxt;
    sum_r <= sum_nxt; num_r <= num_nxt; ps_r <= ps_nxt; neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign status.busy        = mode_r != M_IDLE;
  assign status.fp_zero     = fp_r == '0;
  assign status.fp_small    = mag(fp_r) <= {1'b0, mins_r};
  assign status.delta_small = mag(dl_r) <= {1'b0, tol_r};
  assign status.terms       = (tc_r > 3'(MAX_TERMS)) ? 3'(MAX_TERMS) : tc_r;
  assign x_out              = x_r;

endmodule

@@ rtl/nprt_ctrl.sv @@
// ----------------------------------------------------------------------------
// nprt_ctrl
// Sequencer: runs derivative and polynomial Horner passes, the division and
// the update, and decides when iteration stops.
// ----------------------------------------------------------------------------
module nprt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output nprt_pkg::dp_cmd_t    cmd,
  input  nprt_pkg::dp_status_t status
);
  import nprt_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_DINIT = 13'h0002,
    S_DMUL  = 13'h0004,
    S_DADD  = 13'h0008,
    S_SAVE  = 13'h0010,
    S_CHK   = 13'h0020,
    S_PINIT = 13'h0040,
    S_PMUL  = 13'h0080,
    S_PADD  = 13'h0100,
    S_DIV   = 13'h0200,
    S_STEP  = 13'h0400,
    S_TEST  = 13'h0800,
    S_OUT   = 13'h1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [2:0]      k_r, k_nxt;
  logic [IT_W-1:0] it_r, it_nxt;
  logic [1:0]      st_r, st_nxt;
  logic            iss_r, iss_nxt;
  logic [2:0]      n;

  assign n = status.terms;

  always_comb begin
    state_nxt = state_r; k_nxt = k_r; it_nxt = it_r; st_nxt = st_r; iss_nxt = iss_r;
    cmd.op = OP_NOP; cmd.idx = k_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LDX; it_nxt = '0; state_nxt = S_DINIT;
      end
      S_DINIT: begin
        if (n < 3'd2) begin
          cmd.op = OP_ZERO; state_nxt = S_SAVE;
        end else begin
          cmd.op = OP_LOAD_S; cmd.idx = n - 3'd1; k_nxt = n - 3'd1;
          state_nxt = (n > 3'd2) ? S_DMUL : S_SAVE;
        end
      end
      S_DMUL, S_PMUL, S_DIV: begin
        if (!iss_r) begin
          cmd.op = (state_r == S_DIV) ? OP_DIV : OP_MUL; iss_nxt = 1'b1;
        end else if (!status.busy) begin
          iss_nxt = 1'b0;
          state_nxt = (state_r == S_DMUL) ? S_DADD :
                      (state_r == S_PMUL) ? S_PADD : S_STEP;
        end
      end
      S_DADD: begin
        cmd.op = OP_ADD_S; cmd.idx = k_r - 3'd1; k_nxt = k_r - 3'd1;
        state_nxt = (k_r > 3'd2) ? S_DMUL : S_SAVE;
      end
      S_SAVE: begin
        cmd.op = OP_SAVE_FP; state_nxt = S_CHK;
      end
      S_CHK: begin
        if (status.fp_zero) begin
          st_nxt = ST_ZERO; state_nxt = S_OUT;
        end else if (status.fp_small) begin
          st_nxt = ST_SMALL; state_nxt = S_OUT;
        end else begin
          state_nxt = S_PINIT;
        end
      end
      S_PINIT: begin
        cmd.op = OP_LOAD_C; cmd.idx = n - 3'd1; k_nxt = n - 3'd1; state_nxt = S_PMUL;
      end
      S_PADD: begin
        cmd.op = OP_ADD_C; cmd.idx = k_r - 3'd1; k_nxt = k_r - 3'd1;
        state_nxt = (k_r > 3'd1) ? S_PMUL : S_DIV;
      end
      S_STEP: begin
        cmd.op = OP_STEP; state_nxt = S_TEST;
      end
      S_TEST: begin
        if (status.delta_small) begin
          st_nxt = ST_CONV; state_nxt = S_OUT;
        end else if (it_r == IT_W'(MAX_ITER - 1)) begin
          st_nxt = ST_LIMIT; state_nxt = S_OUT;
        end else begin
          it_nxt = it_r + 1'b1; state_nxt = S_DINIT;
        end
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
    end
    k_r  <= k_nxt;
    it_r <= it_nxt;
    st_r <= st_nxt;
  end

  assign in_stall   = state_r != S_IDLE;
  assign out_valid  = state_r == S_OUT;
  assign out_status = st_r;

endmodule

@@ rtl/newton_polynomial_root.sv @@
// ----------------------------------------------------------------------------
// newton_polynomial_root
// Newton-Raphson root finder for a polynomial of up to five terms, Q31.32.
// ----------------------------------------------------------------------------
// One start point is taken at a time; the next request is accepted after the
// result has been taken. Each Newton iteration with n terms (two to five)
// runs a derivative and a polynomial Horner pass and a bit-serial 128-step
// division; each Horner multiply is sequenced on a shared 32x32 multiplier
// and followed by the add. Up to 64 iterations run per request; with fewer
// than two terms the derivative is zero and no iteration runs.
module newton_polynomial_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_start_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_root_estimate,
  output logic [1:0]  out_status
);
  import nprt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  nprt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .cmd        (cmd),
    .status     (status)
  );

  nprt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start_point (in_start_point),
    .cmd         (cmd),
    .status      (status),
    .x_out       (out_root_estimate)
  );

`ifndef SYNTHESIS
  a_no_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> cmd.op == OP_NOP) else $error("command issued while busy");
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request accepted while result pending");
  a_accept_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid) else $error("result without work");
`endif

endmodule
